>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the superblock parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hsp_pkg.sv
// Package with status codes, field indexes and the signature of the superblock parser.
package hsp_pkg;

    localparam int unsigned STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 2'd3;

    localparam logic [7:0] SIGNATURE [8] = '{
        8'h89, 8'h48, 8'h44, 8'h46, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic [4:0] POS_VERSION    = 5'd8;
    localparam logic [4:0] POS_V2_OSIZE   = 5'd9;
    localparam logic [4:0] POS_V2_LSIZE   = 5'd10;
    localparam logic [4:0] POS_V2_FLAGS   = 5'd11;
    localparam logic [4:0] POS_V2_END     = 5'd12;
    localparam logic [4:0] POS_V0_RSV_LO  = 5'd9;
    localparam logic [4:0] POS_V0_RSV_HI  = 5'd12;
    localparam logic [4:0] POS_V0_OSIZE   = 5'd13;
    localparam logic [4:0] POS_V0_LSIZE   = 5'd14;
    localparam logic [4:0] POS_V0_RSV2    = 5'd15;
    localparam logic [4:0] POS_V0_START   = 5'd24;
    localparam logic [4:0] POS_V1_START   = 5'd28;

    // Field index after a field completes.
    localparam logic [3:0] FLD_BASE   = 4'd1;
    localparam logic [3:0] FLD_EOF    = 4'd3;
    localparam logic [3:0] FLD_V2ROOT = 4'd4;
    localparam logic [3:0] FLD_V0ROOT = 4'd6;
    localparam logic [3:0] FLD_CACHE  = 4'd7;

    // Index of the cache type field while it is being read.
    localparam logic [3:0] FLD_CACHE_READ = 4'd6;
    localparam logic [3:0] CACHE_BYTES    = 4'd4;

    localparam int unsigned OUT_TDATA_W = 144;

    function automatic logic [3:0] size_byte(input logic [7:0] b);
        size_byte = (b > 8'd15) ? 4'd0 : b[3:0];
    endfunction

endpackage

>>> hw/rtl/hdf5_superblock_header_parser_unit.sv
// Top level of the superblock header parser: one byte in per word, one verdict out per file.
//
//  channel   | direction | handshake        | contents
//  ----------+-----------+------------------+-----------------------------------------
//  s_*       | in        | tvalid/tready    | data_byte, first_byte (tuser), last_byte
//  m_*       | out       | tvalid/tready    | one verdict word per parsed header
//  APB       | in        | psel/penable     | file_length at byte address 0
//
// One byte is taken every cycle unless the input side stalls; a byte goes through an
// input register and the parse logic into the result register.
// Reset clears the parse state and leaves the parser idle until a first byte arrives.
// The input side stalls only while the result register holds a word not yet taken.
`include "assert_macros.svh"

module hdf5_superblock_header_parser_unit #(
    parameter int unsigned MAX_ADDRESS_BYTES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] first_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] status, [3:2] header_version, [7:4] offset_bytes, [11:8] length_bytes,
    // [75:12] eof_address, [139:76] root_address, [140] eof_mismatch, rest zero
    output logic [hsp_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int unsigned ACC_BYTES = (MAX_ADDRESS_BYTES > 4) ? MAX_ADDRESS_BYTES : 4;
    localparam int unsigned ACC_W     = 8 * ACC_BYTES;
    localparam int unsigned ADDR_W    = 8 * MAX_ADDRESS_BYTES;
    localparam logic [3:0]  CFG_FILE_LENGTH_ADDR = 4'd0;

    logic [63:0]        file_length_reg;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_first_reg;
    logic               in_last_reg;

    logic [4:0]         pos_reg;
    logic [1:0]         ver_reg;
    logic               ver_valid_reg;
    logic [3:0]         osize_reg;
    logic [3:0]         lsize_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [3:0]         count_reg;
    logic [3:0]         index_reg;
    logic               base_nz_reg;
    logic [ADDR_W-1:0]  eof_reg;
    logic [ADDR_W-1:0]  root_reg;
    logic               done_reg;
    logic               mism_reg;

    logic [4:0]         pos_next;
    logic [1:0]         ver_next;
    logic               ver_valid_next;
    logic [3:0]         osize_next;
    logic [3:0]         lsize_next;
    logic [ACC_W-1:0]   acc_next;
    logic [3:0]         count_next;
    logic [3:0]         index_next;
    logic               base_nz_next;
    logic [ADDR_W-1:0]  eof_next;
    logic [ADDR_W-1:0]  root_next;
    logic               done_next;
    logic               mism_next;

    logic               has_verdict;
    logic [1:0]         verdict;
    logic               fire;

    logic               out_valid_reg;
    logic [hsp_pkg::OUT_TDATA_W-1:0] out_data_reg;

    function automatic logic size_ok(input logic [3:0] s);
        size_ok = (s >= 4'd2) && (s <= 4'(MAX_ADDRESS_BYTES));
    endfunction

    assign pready   = 1'b1;
    assign prdata   = file_length_reg;
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= 64'd0;
        end
        else if (psel && penable && pwrite && pready && (paddr == CFG_FILE_LENGTH_ADDR))
        begin
            file_length_reg <= pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
            in_last_reg  <= s_tlast;
        end
    end

    always_comb
    begin
        logic       active;
        logic [4:0] p;
        logic [3:0] size;
        logic [ACC_W-1:0] v;
        logic       do_field;

        pos_next       = pos_reg;
        ver_next       = ver_reg;
        ver_valid_next = ver_valid_reg;
        osize_next     = osize_reg;
        lsize_next     = lsize_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        index_next     = index_reg;
        base_nz_next   = base_nz_reg;
        eof_next       = eof_reg;
        root_next      = root_reg;
        done_next      = done_reg;
        mism_next      = mism_reg;
        has_verdict    = 1'b0;
        verdict        = hsp_pkg::ST_OK;
        do_field       = 1'b0;
        size           = osize_reg;
        v              = '0;
        active         = !done_reg;

        if (in_first_reg)
        begin
            pos_next       = '0;
            ver_next       = '0;
            ver_valid_next = 1'b0;
            osize_next     = '0;
            lsize_next     = '0;
            acc_next       = '0;
            count_next     = '0;
            index_next     = '0;
            base_nz_next   = 1'b0;
            eof_next       = '0;
            root_next      = '0;
            mism_next      = 1'b0;
            done_next      = 1'b0;
            active         = 1'b1;
        end

        p = pos_next;

        if (in_valid_reg && active)
        begin
            if (p < hsp_pkg::POS_VERSION)
            begin
                if (in_byte_reg != hsp_pkg::SIGNATURE[p[2:0]])
                begin
                    has_verdict = 1'b1;
                    verdict     = hsp_pkg::ST_INVALID;
                end
            end
            else if (p == hsp_pkg::POS_VERSION)
            begin
                if (in_byte_reg > 8'd3)
                begin
                    has_verdict = 1'b1;
                    verdict     = hsp_pkg::ST_INVALID;
                end
                else
                begin
                    ver_next       = in_byte_reg[1:0];
                    ver_valid_next = 1'b1;
                end
            end
            else if (ver_next >= 2'd2)
            begin
                if (p == hsp_pkg::POS_V2_OSIZE)
                begin
                    osize_next = hsp_pkg::size_byte(in_byte_reg);
                end
                else if (p == hsp_pkg::POS_V2_LSIZE)
                begin
                    lsize_next = hsp_pkg::size_byte(in_byte_reg);
                end
                else if (p == hsp_pkg::POS_V2_FLAGS)
                begin
                    if (!size_ok(osize_next) || !size_ok(lsize_next))
                    begin
                        has_verdict = 1'b1;
                        verdict     = hsp_pkg::ST_UNSUPPORTED;
                    end
                end
                else
                begin
                    do_field = 1'b1;
                end
            end
            else if (p >= hsp_pkg::POS_V0_RSV_LO && p <= hsp_pkg::POS_V0_RSV_HI)
            begin
                if (in_byte_reg != 8'd0)
                begin
                    has_verdict = 1'b1;
                    verdict     = hsp_pkg::ST_INVALID;
                end
            end
            else if (p == hsp_pkg::POS_V0_OSIZE)
            begin
                osize_next = hsp_pkg::size_byte(in_byte_reg);
            end
            else if (p == hsp_pkg::POS_V0_LSIZE)
            begin
                lsize_next = hsp_pkg::size_byte(in_byte_reg);
            end
            else if (p == hsp_pkg::POS_V0_RSV2)
            begin
                if (in_byte_reg != 8'd0)
                begin
                    has_verdict = 1'b1;
                    verdict     = hsp_pkg::ST_INVALID;
                end
                else if (!size_ok(osize_next) || !size_ok(lsize_next))
                begin
                    has_verdict = 1'b1;
                    verdict     = hsp_pkg::ST_UNSUPPORTED;
                end
            end
            else if (p >= ((ver_next == 2'd1) ? hsp_pkg::POS_V1_START : hsp_pkg::POS_V0_START))
            begin
                do_field = 1'b1;
            end

            if (do_field)
            begin
                size = ((ver_next < 2'd2) && (index_next == hsp_pkg::FLD_CACHE_READ))
                       ? hsp_pkg::CACHE_BYTES : osize_next;
                for (int k = 0; k < ACC_BYTES; k++)
                begin
                    if (count_next == 4'(k))
                    begin
                        acc_next[8*k +: 8] = acc_next[8*k +: 8] | in_byte_reg;
                    end
                end
                count_next = count_next + 4'd1;
                if (!(count_next < size))
                begin
                    v          = acc_next;
                    acc_next   = '0;
                    count_next = '0;
                    index_next = index_next + 4'd1;
                    if (ver_next < 2'd2)
                    begin
                        case (index_next)
                            hsp_pkg::FLD_BASE:
                            begin
                                if (v != '0)
                                begin
                                    has_verdict = 1'b1;
                                    verdict     = hsp_pkg::ST_UNSUPPORTED;
                                end
                            end
                            hsp_pkg::FLD_EOF:
                            begin
                                eof_next = v[ADDR_W-1:0];
                            end
                            hsp_pkg::FLD_V0ROOT:
                            begin
                                root_next = v[ADDR_W-1:0];
                            end
                            hsp_pkg::FLD_CACHE:
                            begin
                                has_verdict = 1'b1;
                                if (v != '0)
                                begin
                                    verdict = hsp_pkg::ST_UNSUPPORTED;
                                end
                                else
                                begin
                                    mism_next = (64'(eof_next) != file_length_reg);
                                    verdict   = hsp_pkg::ST_OK;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else
                    begin
                        case (index_next)
                            hsp_pkg::FLD_BASE:
                            begin
                                base_nz_next = (v != '0);
                            end
                            hsp_pkg::FLD_EOF:
                            begin
                                eof_next = v[ADDR_W-1:0];
                            end
                            hsp_pkg::FLD_V2ROOT:
                            begin
                                root_next   = v[ADDR_W-1:0];
                                has_verdict = 1'b1;
                                if (base_nz_next)
                                begin
                                    verdict = hsp_pkg::ST_UNSUPPORTED;
                                end
                                else if (64'(eof_next) != file_length_reg)
                                begin
                                    mism_next = 1'b1;
                                    verdict   = hsp_pkg::ST_INVALID;
                                end
                                else
                                begin
                                    verdict = hsp_pkg::ST_OK;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            if (p < hsp_pkg::POS_V2_END || (ver_next < 2'd2 && p < hsp_pkg::POS_V1_START))
            begin
                pos_next = p + 5'd1;
            end

            if (!has_verdict && in_last_reg)
            begin
                has_verdict = 1'b1;
                verdict     = (p < hsp_pkg::POS_VERSION) ? hsp_pkg::ST_INVALID
                                                         : hsp_pkg::ST_TRUNCATED;
            end

            if (has_verdict)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ver_reg       <= '0;
            ver_valid_reg <= 1'b0;
            osize_reg     <= '0;
            lsize_reg     <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            index_reg     <= '0;
            base_nz_reg   <= 1'b0;
            eof_reg       <= '0;
            root_reg      <= '0;
            done_reg      <= 1'b1;
            mism_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                pos_reg       <= pos_next;
                ver_reg       <= ver_next;
                ver_valid_reg <= ver_valid_next;
                osize_reg     <= osize_next;
                lsize_reg     <= lsize_next;
                acc_reg       <= acc_next;
                count_reg     <= count_next;
                index_reg     <= index_next;
                base_nz_reg   <= base_nz_next;
                eof_reg       <= eof_next;
                root_reg      <= root_next;
                done_reg      <= done_next;
                mism_reg      <= mism_next;
            end
            if (fire && has_verdict)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_verdict)
        begin
            out_data_reg <= {3'b000, mism_next, 64'(root_next), 64'(eof_next),
                             size_ok(lsize_next) ? lsize_next : 4'd0,
                             size_ok(osize_next) ? osize_next : 4'd0,
                             ver_valid_next ? ver_next : 2'd0,
                             verdict};
        end
    end

    `ASSERT_IMPL(a_stall_only_when_full, in_valid_reg && !s_tready, out_valid_reg,
        "input stalled while the result register is empty")

    `ASSERT_NEXT(a_done_after_verdict, fire && has_verdict, done_reg,
        "parser still active after a verdict")

    `ASSERT_IMPL(a_ok_has_sizes,
        out_valid_reg && (out_data_reg[1:0] == hsp_pkg::ST_OK),
        (out_data_reg[7:4] != 4'd0) && (out_data_reg[11:8] != 4'd0),
        "ok verdict without valid offset and length sizes")

    `ASSERT_IMPL(a_position_bound, 1'b1, pos_reg <= hsp_pkg::POS_V1_START,
        "byte position ran past the fixed header part")

endmodule

>>> tb/sv/hdf5_superblock_header_parser_unit_test.sv
// Self-checking testbench for the HDF5 superblock header parser unit.
module hdf5_superblock_header_parser_unit_test;

    localparam logic [3:0] FILE_LENGTH_ADDR = 4'h0;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 250;
    localparam int PHASE_VERDICTS = 10;

    typedef struct packed {
        logic        eof_mismatch;
        logic [63:0] root_address;
        logic [63:0] eof_address;
        logic [3:0]  length_bytes;
        logic [3:0]  offset_bytes;
        logic [1:0]  header_version;
        logic [1:0]  status;
    } verdict_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       typed;
        logic [1:0] status;
        logic [1:0] version;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [hsp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    hdf5_superblock_header_parser_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // Parser state mirrored by the predictor.
    logic [63:0] cfg_file_len = '0;
    logic [6:0]  hdr_pos = '0;
    logic [1:0]  hdr_ver = '0;
    logic        ver_known = 1'b0;
    logic [3:0]  off_sz = '0;
    logic [3:0]  len_sz = '0;
    logic [63:0] fld_acc = '0;
    logic [3:0]  fld_cnt = '0;
    logic [3:0]  fld_num = '0;
    logic        base_set = 1'b0;
    logic [63:0] eof_val = '0;
    logic [63:0] root_val = '0;
    logic        idle_now = 1'b1;
    logic        eof_diff = 1'b0;

    verdict_t verdict_q[$];
    int       mismatches = 0;
    int       verdict_total = 0;
    int       byte_total = 0;
    int       status_tally[4] = '{0, 0, 0, 0};
    int       eof_flag_total = 0;
    int       snd_idle_pct = 0;
    int       rcv_idle_pct = 0;
    bit       long_hold_req = 1'b0;

    stim_row_t directed_rows[23] = '{
        '{8'hFF, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h00, 1'b1, 1'b0, 1'b1, hsp_pkg::ST_INVALID,   2'd0},
        '{8'h89, 1'b1, 1'b1, 1'b1, hsp_pkg::ST_INVALID,   2'd0},
        '{8'h89, 1'b1, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h48, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h89, 1'b1, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h48, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h44, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h46, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h0D, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h1A, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b1, hsp_pkg::ST_INVALID,   2'd0},
        '{8'h89, 1'b1, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h48, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h44, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h46, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h0D, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h1A, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, hsp_pkg::ST_OK,        2'd0},
        '{8'h02, 1'b0, 1'b1, 1'b1, hsp_pkg::ST_TRUNCATED, 2'd2}
    };

    function automatic logic [3:0] clip_size(input logic [7:0] b);
        return (b > 8'd15) ? 4'd0 : b[3:0];
    endfunction

    function automatic bit size_in_range(input logic [3:0] s);
        return s >= 4'd2 && s <= 4'd8;
    endfunction

    // Advances the mirrored parser by one word and reports whether a verdict results.
    function automatic bit parse_byte(input logic [7:0] b, input bit first, input bit last,
                                      output verdict_t res);
        logic [6:0]  p;
        logic [1:0]  code;
        bit          decided;
        bit          in_field;
        logic [3:0]  fsize;
        logic [63:0] v;

        res = '0;
        if (first)
        begin
            hdr_pos = '0;
            hdr_ver = '0;
            ver_known = 1'b0;
            off_sz = '0;
            len_sz = '0;
            fld_acc = '0;
            fld_cnt = '0;
            fld_num = '0;
            base_set = 1'b0;
            eof_val = '0;
            root_val = '0;
            eof_diff = 1'b0;
            idle_now = 1'b0;
        end
        else if (idle_now)
        begin
            return 1'b0;
        end

        p = hdr_pos;
        code = hsp_pkg::ST_OK;
        decided = 1'b0;
        in_field = 1'b0;
        if (p < 7'd8)
        begin
            if (b != hsp_pkg::SIGNATURE[p[2:0]])
            begin
                code = hsp_pkg::ST_INVALID;
                decided = 1'b1;
            end
        end
        else if (p == 7'd8)
        begin
            if (b > 8'd3)
            begin
                code = hsp_pkg::ST_INVALID;
                decided = 1'b1;
            end
            else
            begin
                hdr_ver = b[1:0];
                ver_known = 1'b1;
            end
        end
        else if (hdr_ver >= 2'd2)
        begin
            if (p == 7'd9)
                off_sz = clip_size(b);
            else if (p == 7'd10)
                len_sz = clip_size(b);
            else if (p == 7'd11)
            begin
                if (!size_in_range(off_sz) || !size_in_range(len_sz))
                begin
                    code = hsp_pkg::ST_UNSUPPORTED;
                    decided = 1'b1;
                end
            end
            else
                in_field = 1'b1;
        end
        else if (p >= 7'd9 && p <= 7'd12)
        begin
            if (b != 8'd0)
            begin
                code = hsp_pkg::ST_INVALID;
                decided = 1'b1;
            end
        end
        else if (p == 7'd13)
            off_sz = clip_size(b);
        else if (p == 7'd14)
            len_sz = clip_size(b);
        else if (p == 7'd15)
        begin
            if (b != 8'd0)
            begin
                code = hsp_pkg::ST_INVALID;
                decided = 1'b1;
            end
            else if (!size_in_range(off_sz) || !size_in_range(len_sz))
            begin
                code = hsp_pkg::ST_UNSUPPORTED;
                decided = 1'b1;
            end
        end
        else if (p >= ((hdr_ver == 2'd1) ? 7'd28 : 7'd24))
            in_field = 1'b1;

        if (in_field)
        begin
            fsize = (hdr_ver < 2'd2 && fld_num == 4'd6) ? 4'd4 : off_sz;
            if (fld_cnt < 4'd8)
                fld_acc = fld_acc | (64'(b) << (8 * fld_cnt));
            fld_cnt = fld_cnt + 4'd1;
            if (fld_cnt >= fsize)
            begin
                v = fld_acc;
                fld_acc = '0;
                fld_cnt = '0;
                fld_num = fld_num + 4'd1;
                if (hdr_ver < 2'd2)
                begin
                    case (fld_num)
                        4'd1:
                            if (v != 64'd0)
                            begin
                                code = hsp_pkg::ST_UNSUPPORTED;
                                decided = 1'b1;
                            end
                        4'd3: eof_val = v;
                        4'd6: root_val = v;
                        4'd7:
                        begin
                            decided = 1'b1;
                            if (v != 64'd0)
                                code = hsp_pkg::ST_UNSUPPORTED;
                            else
                            begin
                                eof_diff = (eof_val != cfg_file_len);
                                code = hsp_pkg::ST_OK;
                            end
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    case (fld_num)
                        4'd1: base_set = (v != 64'd0);
                        4'd3: eof_val = v;
                        4'd4:
                        begin
                            root_val = v;
                            decided = 1'b1;
                            if (base_set)
                                code = hsp_pkg::ST_UNSUPPORTED;
                            else if (eof_val != cfg_file_len)
                            begin
                                eof_diff = 1'b1;
                                code = hsp_pkg::ST_INVALID;
                            end
                            else
                                code = hsp_pkg::ST_OK;
                        end
                        default: ;
                    endcase
                end
            end
        end

        if (p < 7'd12 || (hdr_ver < 2'd2 && p < 7'd28))
            hdr_pos = p + 7'd1;

        if (!decided)
        begin
            if (!last)
                return 1'b0;
            code = (p < 7'd8) ? hsp_pkg::ST_INVALID : hsp_pkg::ST_TRUNCATED;
        end
        idle_now = 1'b1;
        res.status = code;
        res.header_version = ver_known ? hdr_ver : 2'd0;
        res.offset_bytes = size_in_range(off_sz) ? off_sz : 4'd0;
        res.length_bytes = size_in_range(len_sz) ? len_sz : 4'd0;
        res.eof_address = eof_val;
        res.root_address = root_val;
        res.eof_mismatch = eof_diff;
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit first, input bit last,
                             input bit typed, input verdict_t typed_v);
        verdict_t v;
        bit       got;

        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= first;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        got = parse_byte(b, first, last, v);
        if (got)
        begin
            if (typed)
                v = typed_v;
            verdict_q.push_back(v);
            verdict_total++;
            status_tally[v.status]++;
            if (v.eof_mismatch)
                eof_flag_total++;
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_file_length(input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= FILE_LENGTH_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cfg_file_len = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin : result_sink
        verdict_t got_v;
        verdict_t want;
        int       hold_left;

        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got_v = verdict_t'(m_tdata[140:0]);
                if (verdict_q.size() == 0)
                begin
                    $error("verdict word with none expected: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got_v.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got_v.status);
                        mismatches++;
                    end
                    if (got_v.header_version !== want.header_version)
                    begin
                        $error("header_version: expected %0d, actual %0d",
                               want.header_version, got_v.header_version);
                        mismatches++;
                    end
                    if (got_v.offset_bytes !== want.offset_bytes)
                    begin
                        $error("offset_bytes: expected %0d, actual %0d",
                               want.offset_bytes, got_v.offset_bytes);
                        mismatches++;
                    end
                    if (got_v.length_bytes !== want.length_bytes)
                    begin
                        $error("length_bytes: expected %0d, actual %0d",
                               want.length_bytes, got_v.length_bytes);
                        mismatches++;
                    end
                    if (got_v.eof_address !== want.eof_address)
                    begin
                        $error("eof_address: expected %h, actual %h",
                               want.eof_address, got_v.eof_address);
                        mismatches++;
                    end
                    if (got_v.root_address !== want.root_address)
                    begin
                        $error("root_address: expected %h, actual %h",
                               want.root_address, got_v.root_address);
                        mismatches++;
                    end
                    if (got_v.eof_mismatch !== want.eof_mismatch)
                    begin
                        $error("eof_mismatch: expected %0d, actual %0d",
                               want.eof_mismatch, got_v.eof_mismatch);
                        mismatches++;
                    end
                    if (m_tdata[hsp_pkg::OUT_TDATA_W-1:141] !== '0)
                    begin
                        $error("padding: expected 0, actual %h",
                               m_tdata[hsp_pkg::OUT_TDATA_W-1:141]);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Stalled for %0d cycles with %0d verdicts outstanding.",
                         quiet, verdict_q.size());
                $display("hdf5_superblock_header_parser_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0]  hdr[$];
        logic [63:0] fld;
        logic [7:0]  osz_b;
        logic [7:0]  lsz_b;
        verdict_t    tv;
        int          phase;
        int          j;
        int          k;
        int          w;
        int          nfld;
        int          ver;
        int          cut;
        int          run_bytes;
        int          run_start;
        bit          paused;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_file_length(64'd0);

        snd_idle_pct = 10;
        rcv_idle_pct = 71;
        foreach (directed_rows[i])
        begin
            tv = '0;
            tv.status = directed_rows[i].status;
            tv.header_version = directed_rows[i].version;
            push_byte(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].typed, tv);
            byte_total++;
        end

        for (phase = 0; phase < 6; phase++)
        begin
            wait_for_results();
            case (phase)
                0: write_file_length(64'hFFFF_FFFF_FFFF_FFFF);
                1: write_file_length(64'($urandom_range(65535)));
                2: write_file_length({$urandom, $urandom});
                3: write_file_length(64'd0);
                4: write_file_length(64'($urandom_range(255)));
                default: write_file_length(64'hFFFF_FFFF_FFFF_FFFF);
            endcase
            snd_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 71 : 0;
            rcv_idle_pct = (phase < 2) ? 71 : (phase < 4) ? 10 : 0;
            if (phase == 1)
                long_hold_req = 1'b1;
            run_bytes = 0;
            run_start = verdict_total;
            paused = 1'b0;
            while (run_bytes < PHASE_BYTES || verdict_total - run_start < PHASE_VERDICTS)
            begin
                if (!paused && run_bytes >= PHASE_BYTES / 2)
                begin
                    wait_for_results();
                    paused = 1'b1;
                end

                hdr.delete();
                for (k = 0; k < 8; k++)
                    hdr.push_back(hsp_pkg::SIGNATURE[k]);
                ver = $urandom_range(3);
                hdr.push_back(8'(ver));
                osz_b = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                        : 8'($urandom_range(2, ($urandom_range(3) == 0) ? 8 : 4));
                lsz_b = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                        : 8'($urandom_range(2, 8));
                w = (osz_b >= 2 && osz_b <= 8) ? int'(osz_b) : 2;
                if (ver >= 2)
                begin
                    hdr.push_back(osz_b);
                    hdr.push_back(lsz_b);
                    hdr.push_back(8'($urandom_range(255)));
                    nfld = 4;
                end
                else
                begin
                    for (k = 0; k < 4; k++)
                        hdr.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'd0);
                    hdr.push_back(osz_b);
                    hdr.push_back(lsz_b);
                    hdr.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'd0);
                    for (k = 0; k < ((ver == 1) ? 12 : 8); k++)
                        hdr.push_back(8'($urandom_range(255)));
                    nfld = 6;
                end
                for (j = 0; j < nfld; j++)
                begin
                    fld = {$urandom, $urandom};
                    if (j == 0 && $urandom_range(9) != 0)
                        fld = '0;
                    if (j == 2 && $urandom_range(1) == 1)
                        fld = cfg_file_len;
                    for (k = 0; k < w; k++)
                        hdr.push_back(fld[8*k +: 8]);
                end
                if (ver < 2)
                begin
                    for (k = 0; k < 4; k++)
                        hdr.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'd0);
                end

                if ($urandom_range(9) == 0)
                    hdr[$urandom_range(hdr.size() - 1)] = 8'($urandom_range(255));
                if ($urandom_range(11) == 0)
                begin
                    cut = $urandom_range(1, hdr.size() - 1);
                    while (hdr.size() > cut)
                        void'(hdr.pop_back());
                end
                if ($urandom_range(19) == 0 && hdr.size() > 1)
                begin
                    cut = $urandom_range(1, hdr.size() - 1);
                    for (k = 0; k < cut; k++)
                    begin
                        push_byte(hdr[k], k == 0, 1'b0, 1'b0, '0);
                        run_bytes++;
                    end
                end
                for (k = 0; k < hdr.size(); k++)
                begin
                    push_byte(hdr[k], k == 0, k == hdr.size() - 1, 1'b0, '0);
                    run_bytes++;
                end
                if ($urandom_range(4) == 0)
                begin
                    for (k = $urandom_range(1, 3); k > 0; k--)
                        push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                                  1'b0, '0);
                end
            end
            byte_total += run_bytes;
        end

        wait_for_results();
        $display("Sent %0d header words over six file length settings and three idle mixes.",
                 byte_total);
        $display("Verdicts: %0d ok, %0d invalid, %0d unsupported, %0d truncated, %0d eof flags.",
                 status_tally[hsp_pkg::ST_OK], status_tally[hsp_pkg::ST_INVALID],
                 status_tally[hsp_pkg::ST_UNSUPPORTED], status_tally[hsp_pkg::ST_TRUNCATED],
                 eof_flag_total);
        if (mismatches == 0)
            $display("hdf5_superblock_header_parser_unit regression: pass");
        else
            $display("hdf5_superblock_header_parser_unit regression: fail");
        $finish;
    end

endmodule
